>>> hdl/ae_pkg.sv
package ae_pkg;

    localparam int CODE_BITS_DEF  = 32;
    localparam int FREQ_BITS_DEF  = 16;
    localparam int MAX_FOLLOW_DEF = 32;

    // bytes reported per item; later bytes only counted
    localparam int MAX_RESULTS = 12;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int N_W         = $clog2(MAX_RESULTS + 1);
    localparam int PUSH_W      = 8;

    // remainder width: divisor is at most 17 bits
    localparam int DIV_REM_W = 18;
    localparam int FC_W      = 7;

    localparam logic [3:0] PL_FULL = 4'd8;

    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FOLLOW  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic start;
        logic load;
        logic put;
        logic bit_val;
        logic flush;
        logic commit;
    } pack_cmd_t;

endpackage

>>> hdl/ae_item_if.sv
interface ae_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] sym_low;
    logic [16:0] sym_high;
    logic [16:0] sym_total;

    modport source (output valid, func, sym_low, sym_high, sym_total, input ready);
    modport sink   (input valid, func, sym_low, sym_high, sym_total, output ready);
endinterface

>>> hdl/ae_result_if.sv
interface ae_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [1:0]  status;
    logic [31:0] total_bytes;

    modport source (output valid, out_byte, byte_valid, last, status, total_bytes,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, last, status, total_bytes,
                    output ready);
endinterface

>>> hdl/ae_div.sv
// restoring shift-subtract divider, one quotient bit per cycle
module ae_div #(
    parameter int CODE_BITS = ae_pkg::CODE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CODE_BITS-1:0] dividend,
    input  logic [16:0]          divisor,
    output logic                 done,
    output logic [CODE_BITS-1:0] quotient
);
    localparam int CW = $clog2(CODE_BITS + 1);

    logic [CODE_BITS-1:0]          q_reg, q_next;
    logic [ae_pkg::DIV_REM_W-1:0]  rem_reg, rem_next;
    logic [16:0]                   d_reg, d_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ae_pkg::DIV_REM_W-1:0]  trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[ae_pkg::DIV_REM_W-2:0], q_reg[CODE_BITS-1]};
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = CW'(CODE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= ae_pkg::DIV_REM_W'(d_reg))
            begin
                rem_next = trial - ae_pkg::DIV_REM_W'(d_reg);
                q_next   = {q_reg[CODE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[CODE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

>>> hdl/ae_pack.sv
// MSB-first bit packer with per-item byte buffer; working copy commits or drops
module ae_pack (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ae_pkg::pack_cmd_t         cmd,
    input  logic [ae_pkg::IDX_W-1:0]  rd_idx,
    output logic [7:0]                rd_byte,
    output logic [ae_pkg::N_W-1:0]    count,
    output logic [ae_pkg::PUSH_W-1:0] pushes
);
    logic [7:0]                pb_reg, pb_next;
    logic [3:0]                pl_reg, pl_next;
    logic [7:0]                wpb_reg, wpb_next;
    logic [3:0]                wpl_reg, wpl_next;
    logic [ae_pkg::N_W-1:0]    n_reg, n_next;
    logic [ae_pkg::PUSH_W-1:0] push_reg, push_next;
    logic [7:0]                buf_reg [ae_pkg::MAX_RESULTS];
    logic                      do_push;
    logic [7:0]                push_byte;
    logic [7:0]                sh;
    logic [3:0]                pl_dec;
    logic [15:0]               padded;

    always_comb
    begin
        pb_next   = pb_reg;
        pl_next   = pl_reg;
        wpb_next  = wpb_reg;
        wpl_next  = wpl_reg;
        n_next    = n_reg;
        push_next = push_reg;
        do_push   = 1'b0;
        push_byte = 8'd0;
        sh        = {wpb_reg[6:0], cmd.bit_val};
        pl_dec    = (wpl_reg != 4'd0) ? wpl_reg - 4'd1 : wpl_reg;
        padded    = {8'd0, wpb_reg} << wpl_reg;
        if (cmd.start)
        begin
            pb_next = 8'd0;
            pl_next = ae_pkg::PL_FULL;
        end
        else if (cmd.load)
        begin
            wpb_next  = pb_reg;
            wpl_next  = pl_reg;
            n_next    = '0;
            push_next = '0;
        end
        else if (cmd.put)
        begin
            wpb_next = sh;
            wpl_next = pl_dec;
            if (pl_dec == 4'd0)
            begin
                do_push   = 1'b1;
                push_byte = sh;
                wpb_next  = 8'd0;
                wpl_next  = ae_pkg::PL_FULL;
            end
        end
        else if (cmd.flush)
        begin
            if (wpl_reg != ae_pkg::PL_FULL && wpl_reg != 4'd0)
            begin
                do_push   = 1'b1;
                push_byte = padded[7:0];
            end
            wpb_next = 8'd0;
            wpl_next = ae_pkg::PL_FULL;
        end
        else if (cmd.commit)
        begin
            pb_next = wpb_reg;
            pl_next = wpl_reg;
        end
        if (do_push)
        begin
            push_next = push_reg + ae_pkg::PUSH_W'(1);
            if (n_reg < ae_pkg::N_W'(ae_pkg::MAX_RESULTS))
            begin
                n_next = n_reg + ae_pkg::N_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg   <= 8'd0;
            pl_reg   <= ae_pkg::PL_FULL;
            wpb_reg  <= 8'd0;
            wpl_reg  <= ae_pkg::PL_FULL;
            n_reg    <= '0;
            push_reg <= '0;
        end
        else
        begin
            pb_reg   <= pb_next;
            pl_reg   <= pl_next;
            wpb_reg  <= wpb_next;
            wpl_reg  <= wpl_next;
            n_reg    <= n_next;
            push_reg <= push_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && n_reg < ae_pkg::N_W'(ae_pkg::MAX_RESULTS))
        begin
            buf_reg[n_reg[ae_pkg::IDX_W-1:0]] <= push_byte;
        end
    end

    assign rd_byte = buf_reg[rd_idx];
    assign count   = n_reg;
    assign pushes  = push_reg;
endmodule

>>> hdl/arithmetic_encoder_shift_add_unit.sv
// Low-precision arithmetic encoder. One item at a time: item.ready is high
// only in idle. A start item resets the coder and answers next cycle. An
// encode item runs a CODE_BITS-step shift-subtract divider for
// r = range/total; then come r*low and r*high in turn on the shared
// multiplier, a narrowing step, the renormalization steps plus a final
// range check, the emitted bits (each bit and its pending follow bits,
// serial through the packer) and a commit step before the first result. A
// finish item sends all CODE_BITS bits of low with their follow bits and
// flushes a padded partial byte. Bytes of an item are buffered (up to 12)
// so that a follow overflow can drop the whole item; results are then sent
// one per transfer. An item with no byte gives one result with byte_valid
// low and last high.
module arithmetic_encoder_shift_add_unit #(
    parameter int CODE_BITS  = ae_pkg::CODE_BITS_DEF,
    parameter int FREQ_BITS  = ae_pkg::FREQ_BITS_DEF,
    parameter int MAX_FOLLOW = ae_pkg::MAX_FOLLOW_DEF
) (
    input logic         clk,
    input logic         rst_n,
    ae_item_if.sink     item,
    ae_result_if.source result
);
    localparam int IW = $clog2(CODE_BITS);
    localparam int FW = ae_pkg::FC_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DIV    = 11'b00000000010,
        S_MUL1   = 11'b00000000100,
        S_MUL2   = 11'b00000001000,
        S_NARROW = 11'b00000010000,
        S_REN    = 11'b00000100000,
        S_EMIT   = 11'b00001000000,
        S_FIN    = 11'b00010000000,
        S_FLUSH  = 11'b00100000000,
        S_DONE   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    localparam logic [CODE_BITS:0]   HALF_W    = (CODE_BITS+1)'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS:0]   QUARTER_W = (CODE_BITS+1)'(1) << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] HALF_C    = CODE_BITS'(1) << (CODE_BITS - 1);

    state_t                      state_reg, state_next;
    // committed coder state
    logic [CODE_BITS-1:0]        lo_reg, lo_next;
    logic [CODE_BITS-1:0]        rg_reg, rg_next;
    logic [5:0]                  fc_reg, fc_next;
    logic [31:0]                 nb_reg, nb_next;
    logic                        halted_reg, halted_next;
    // working copies for the item in flight
    logic [CODE_BITS:0]          low_reg, low_next;
    logic [CODE_BITS-1:0]        rgw_reg, rgw_next;
    logic [FW-1:0]               fcw_reg, fcw_next;
    logic [CODE_BITS-1:0]        t1_reg, t1_next;
    logic [CODE_BITS-1:0]        t2_reg, t2_next;
    logic [15:0]                 slo_reg, slo_next;
    logic [16:0]                 shi_reg, shi_next;
    logic [16:0]                 stot_reg, stot_next;
    logic                        fin_reg, fin_next;
    logic                        pend_reg, pend_next;
    logic                        first_reg, first_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic                        fdone_reg, fdone_next;
    logic                        none_reg, none_next;
    logic [1:0]                  status_reg, status_next;
    logic [31:0]                 base_reg, base_next;
    logic [ae_pkg::IDX_W-1:0]    k_reg, k_next;

    ae_pkg::pack_cmd_t           pk_cmd;
    logic [7:0]                  pk_byte;
    logic [ae_pkg::N_W-1:0]      pk_count;
    logic [ae_pkg::PUSH_W-1:0]   pk_pushes;

    logic                        div_start;
    logic                        div_done;
    logic [CODE_BITS-1:0]        div_q;

    logic [16:0]                 mul_b;
    logic [CODE_BITS+16:0]       prod;
    logic [CODE_BITS-1:0]        nr;
    logic [CODE_BITS+1:0]        lo_plus_rg;
    logic                        bad_iv;
    logic                        item_xfer;
    logic                        res_xfer;
    logic                        no_bytes;
    logic                        is_last;
    logic                        emit_rem_zero;

    ae_div #(.CODE_BITS(CODE_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rg_reg),
        .divisor  (item.sym_total),
        .done     (div_done),
        .quotient (div_q)
    );

    ae_pack u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pk_cmd),
        .rd_idx  (k_reg),
        .rd_byte (pk_byte),
        .count   (pk_count),
        .pushes  (pk_pushes)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign res_xfer   = result.valid && result.ready;

    // interval check on the incoming item
    assign bad_iv = (item.sym_total == 17'd0) ||
                    ({15'd0, item.sym_total} > (32'd1 << FREQ_BITS)) ||
                    (item.sym_high > item.sym_total) ||
                    ({1'b0, item.sym_low} >= item.sym_high);

    // shared multiplier: r*low then r*high
    assign mul_b = (state_reg == S_MUL1) ? {1'b0, slo_reg} : shi_reg;
    assign prod  = div_q * mul_b;
    // top symbol takes the excess range
    assign nr    = (shi_reg < stot_reg) ? (t2_reg - t1_reg) : (rgw_reg - t1_reg);
    assign lo_plus_rg = {1'b0, low_reg} + (CODE_BITS+2)'(rgw_reg);

    assign emit_rem_zero = first_reg ? (fcw_reg == '0) : (fcw_reg == FW'(1));

    assign no_bytes = none_reg || (pk_count == '0);
    assign is_last  = no_bytes || ((ae_pkg::N_W'(k_reg) + ae_pkg::N_W'(1)) == pk_count);

    assign result.valid       = (state_reg == S_OUT);
    assign result.out_byte    = no_bytes ? 8'd0 : pk_byte;
    assign result.byte_valid  = !no_bytes;
    assign result.last        = is_last;
    assign result.status      = status_reg;
    assign result.total_bytes = no_bytes ? base_reg : base_reg + 32'(k_reg) + 32'd1;

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        rg_next     = rg_reg;
        fc_next     = fc_reg;
        nb_next     = nb_reg;
        halted_next = halted_reg;
        low_next    = low_reg;
        rgw_next    = rgw_reg;
        fcw_next    = fcw_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        slo_next    = slo_reg;
        shi_next    = shi_reg;
        stot_next   = stot_reg;
        fin_next    = fin_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        idx_next    = idx_reg;
        fdone_next  = fdone_reg;
        none_next   = none_reg;
        status_next = status_reg;
        base_next   = base_reg;
        k_next      = k_reg;
        pk_cmd      = '0;
        div_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    base_next   = nb_reg;
                    k_next      = '0;
                    none_next   = 1'b1;
                    status_next = ae_pkg::ST_OK;
                    slo_next    = item.sym_low;
                    shi_next    = item.sym_high;
                    stot_next   = item.sym_total;
                    low_next    = {1'b0, lo_reg};
                    rgw_next    = rg_reg;
                    fcw_next    = FW'(fc_reg);
                    state_next  = S_OUT;
                    if (item.func == ae_pkg::FUNC_START)
                    begin
                        lo_next      = '0;
                        rg_next      = HALF_C;
                        fc_next      = '0;
                        halted_next  = 1'b0;
                        pk_cmd.start = 1'b1;
                    end
                    else if (item.func != ae_pkg::FUNC_ENCODE &&
                             item.func != ae_pkg::FUNC_FINISH)
                    begin
                        status_next = ae_pkg::ST_INVALID;
                    end
                    else if (halted_reg)
                    begin
                        status_next = ae_pkg::ST_FOLLOW;
                    end
                    else if (item.func == ae_pkg::FUNC_ENCODE)
                    begin
                        if (bad_iv)
                        begin
                            status_next = ae_pkg::ST_INVALID;
                        end
                        else
                        begin
                            none_next   = 1'b0;
                            fin_next    = 1'b0;
                            pk_cmd.load = 1'b1;
                            div_start   = 1'b1;
                            state_next  = S_DIV;
                        end
                    end
                    else
                    begin
                        none_next   = 1'b0;
                        fin_next    = 1'b1;
                        fdone_next  = 1'b0;
                        idx_next    = IW'(CODE_BITS - 1);
                        pk_cmd.load = 1'b1;
                        state_next  = S_FIN;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                t1_next    = prod[CODE_BITS-1:0];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                t2_next    = prod[CODE_BITS-1:0];
                state_next = S_NARROW;
            end
            S_NARROW:
            begin
                if (nr == '0)
                begin
                    none_next   = 1'b1;
                    status_next = ae_pkg::ST_INVALID;
                    state_next  = S_OUT;
                end
                else
                begin
                    low_next   = low_reg + (CODE_BITS+1)'(t1_reg);
                    rgw_next   = nr;
                    state_next = S_REN;
                end
            end
            S_REN:
            begin
                if ((CODE_BITS+1)'(rgw_reg) > QUARTER_W)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rgw_next = {rgw_reg[CODE_BITS-2:0], 1'b0};
                    if (low_reg >= HALF_W)
                    begin
                        low_next   = (low_reg - HALF_W) << 1;
                        pend_next  = 1'b1;
                        first_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else if (lo_plus_rg <= (CODE_BITS+2)'(HALF_W))
                    begin
                        low_next   = low_reg << 1;
                        pend_next  = 1'b0;
                        first_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        low_next = (low_reg - QUARTER_W) << 1;
                        fcw_next = fcw_reg + FW'(1);
                    end
                end
            end
            S_EMIT:
            begin
                // the bit itself, then the pending opposite follow bits
                pk_cmd.put     = 1'b1;
                pk_cmd.bit_val = first_reg ? pend_reg : !pend_reg;
                first_next     = 1'b0;
                if (!first_reg)
                begin
                    fcw_next = fcw_reg - FW'(1);
                end
                if (emit_rem_zero)
                begin
                    state_next = fin_reg ? S_FIN : S_REN;
                end
            end
            S_FIN:
            begin
                if (fdone_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    pend_next  = low_reg[idx_reg];
                    first_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        fdone_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                    state_next = S_EMIT;
                end
            end
            S_FLUSH:
            begin
                pk_cmd.flush = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!fin_reg && fcw_reg > FW'(MAX_FOLLOW))
                begin
                    // whole item dropped
                    halted_next = 1'b1;
                    none_next   = 1'b1;
                    status_next = ae_pkg::ST_FOLLOW;
                end
                else
                begin
                    lo_next       = low_reg[CODE_BITS-1:0];
                    rg_next       = rgw_reg;
                    fc_next       = fcw_reg[5:0];
                    nb_next       = base_reg + 32'(pk_pushes);
                    pk_cmd.commit = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_xfer)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + ae_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lo_reg     <= '0;
            rg_reg     <= HALF_C;
            fc_reg     <= '0;
            nb_reg     <= '0;
            halted_reg <= 1'b0;
            fin_reg    <= 1'b0;
            first_reg  <= 1'b0;
            fdone_reg  <= 1'b0;
            none_reg   <= 1'b1;
            k_reg      <= '0;
            idx_reg    <= '0;
            fcw_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lo_reg     <= lo_next;
            rg_reg     <= rg_next;
            fc_reg     <= fc_next;
            nb_reg     <= nb_next;
            halted_reg <= halted_next;
            fin_reg    <= fin_next;
            first_reg  <= first_next;
            fdone_reg  <= fdone_next;
            none_reg   <= none_next;
            k_reg      <= k_next;
            idx_reg    <= idx_next;
            fcw_reg    <= fcw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg    <= low_next;
        rgw_reg    <= rgw_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        slo_reg    <= slo_next;
        shi_reg    <= shi_next;
        stot_reg   <= stot_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
        base_reg   <= base_next;
    end

    // never accepting while a result is offered
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(item.ready && result.valid))
        else $error("item accepted while result pending");

    // a non-final byte transfer is followed by another result
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (res_xfer && !result.last) |=> result.valid)
        else $error("result run cut short");

    // divider finishes only while the sequencer waits for it
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("stray divider completion");
endmodule
